[rtl/uart_reply_framer_init_sequencer_top_macros.svh]
// assertion macros shared by the reply framer and init sequencer rtl
// expects i_clk and i_rst_n in the scope of every use
`ifndef UART_REPLY_FRAMER_INIT_SEQUENCER_TOP_MACROS_SVH
`define UART_REPLY_FRAMER_INIT_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define URF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define URF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define URF_ASSERT_SAME(label, ante, cons)

`define URF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/urf_pkg.sv]
// types and constants for the reply framer and init sequencer
// no dependencies
`default_nettype none

package urf_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       frame_end;
        logic       reply_accepted;
        logic [2:0] command_issued;
        logic [2:0] sequence_step;
        logic       data_mode;
    } t_out_item;

    typedef struct packed {
        logic frame_end;
        logic reply_accepted;
    } t_frame_evt;

    typedef struct packed {
        logic [2:0] command_issued;
        logic [2:0] sequence_step;
        logic       data_mode;
    } t_seq_res;

    localparam logic [1:0] OP_BYTE       = 2'd0;
    localparam logic [1:0] OP_START_COLD = 2'd1;
    localparam logic [1:0] OP_START_WARM = 2'd2;

    localparam logic [2:0] CMD_IDLE     = 3'd0;
    localparam logic [2:0] CMD_ENTER    = 3'd1;
    localparam logic [2:0] CMD_DUMP     = 3'd2;
    localparam logic [2:0] CMD_GET_NAME = 3'd3;
    localparam logic [2:0] CMD_VERSION  = 3'd4;
    localparam logic [2:0] CMD_SET_SVC  = 3'd5;
    localparam logic [2:0] CMD_RESTART  = 3'd6;

    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [1:0] PROMPT_LAST = 2'd3;
    localparam logic [2:0] REBOOT_LAST = 3'd5;

    function automatic logic [7:0] prompt_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0: ch = 8'h43;
            2'd1: ch = 8'h4D;
            2'd2: ch = 8'h44;
            default: ch = 8'h3E;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] reboot_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h52;
            3'd1: ch = 8'h45;
            3'd2: ch = 8'h42;
            3'd3: ch = 8'h4F;
            3'd4: ch = 8'h4F;
            3'd5: ch = 8'h54;
            default: ch = 8'h52;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/uart_reply_framer_init_sequencer_top.sv]
// top level of the uart reply framer and init sequencer
// depends on urf_pkg, urf_framer, urf_sequencer and the macros header
//
//  channel | direction | payload     | handshake
//  in      | input     | t_in_item   | i_in_valid / o_in_stall
//  out     | output    | t_out_item  | o_out_valid / i_out_stall
//
// one item per cycle sustained while the output is not stalled; a result
// item is valid from the edge that loads the output register, and framing
// and chain state update in one pass between input and output registers
// i_rst_n is synchronous and clears the state and both valid flags
// a stalled output holds the input register, and the input stalls in turn
`default_nettype none

module uart_reply_framer_init_sequencer_top #(
    parameter int FRAME_BYTES = 256
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire urf_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output urf_pkg::t_out_item      o_out_item
);
    import urf_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       fire;
    t_frame_evt evt;
    t_seq_res   res;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    urf_framer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_evt   (evt)
    );

    urf_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (r_in_item.op),
        .i_evt   (evt),
        .o_res   (res)
    );

    always_comb begin
        n_out_item.frame_end      = evt.frame_end;
        n_out_item.reply_accepted = evt.reply_accepted;
        n_out_item.command_issued = res.command_issued;
        n_out_item.sequence_step  = res.sequence_step;
        n_out_item.data_mode      = res.data_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`include "uart_reply_framer_init_sequencer_top_macros.svh"

    `URF_ASSERT_SAME(a_acc_needs_end, r_out_valid && r_out_item.reply_accepted,
        r_out_item.frame_end)
    `URF_ASSERT_SAME(a_issue_is_step,
        r_out_valid && (r_out_item.command_issued != CMD_IDLE),
        r_out_item.sequence_step == r_out_item.command_issued)

endmodule

`default_nettype wire

[rtl/urf_framer.sv]
// reply framer: byte count, percent tracking and prompt/reboot text match
// depends on urf_pkg
`default_nettype none

module urf_framer #(
    parameter int FRAME_BYTES = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_fire,
    input  wire urf_pkg::t_in_item   i_item,
    output urf_pkg::t_frame_evt      o_evt
);
    import urf_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_pct, n_pct;
    logic [1:0]       r_pm, n_pm;
    logic [2:0]       r_rm, n_rm;
    logic             r_pf, n_pf;
    logic             r_rf, n_rf;
    logic             r_nul, n_nul;

    logic [POS_W-1:0] pos_inc;
    logic [1:0]       m_pm;
    logic [2:0]       m_rm;
    logic             m_pf, m_rf, m_nul;
    logic             is_byte, fend;
    logic [7:0]       b;

    assign b       = i_item.rx_byte;
    assign is_byte = (i_item.op == OP_BYTE);
    assign pos_inc = r_pos + POS_W'(1);
    assign fend    = (b == CH_GT) || ((b == CH_PERCENT) && r_pct);

    // text match on this byte, blocked after the first nul
    always_comb begin
        m_pm  = r_pm;
        m_rm  = r_rm;
        m_pf  = r_pf;
        m_rf  = r_rf;
        m_nul = r_nul;
        if (!r_nul) begin
            if (b == CH_NUL) begin
                m_nul = 1'b1;
            end else begin
                if (b == prompt_char(r_pm)) begin
                    if (r_pm == PROMPT_LAST) begin
                        m_pf = 1'b1;
                        m_pm = 2'd0;
                    end else begin
                        m_pm = r_pm + 2'd1;
                    end
                end else begin
                    m_pm = (b == prompt_char(2'd0)) ? 2'd1 : 2'd0;
                end
                if (b == reboot_char(r_rm)) begin
                    if (r_rm == REBOOT_LAST) begin
                        m_rf = 1'b1;
                        m_rm = 3'd0;
                    end else begin
                        m_rm = r_rm + 3'd1;
                    end
                end else begin
                    m_rm = (b == reboot_char(3'd0)) ? 3'd1 : 3'd0;
                end
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_pct = r_pct;
        n_pm  = r_pm;
        n_rm  = r_rm;
        n_pf  = r_pf;
        n_rf  = r_rf;
        n_nul = r_nul;
        o_evt.frame_end      = 1'b0;
        o_evt.reply_accepted = 1'b0;
        if (is_byte) begin
            if (fend) begin
                o_evt.frame_end      = 1'b1;
                o_evt.reply_accepted = m_pf | m_rf;
                n_pos = '0;
                n_pct = 1'b0;
                n_pm  = '0;
                n_rm  = '0;
                n_pf  = 1'b0;
                n_rf  = 1'b0;
                n_nul = 1'b0;
            end else if (pos_inc >= POS_LIMIT) begin
                // size limit restart keeps the percent flag
                n_pos = '0;
                n_pct = r_pct | (b == CH_PERCENT);
                n_pm  = '0;
                n_rm  = '0;
                n_pf  = 1'b0;
                n_rf  = 1'b0;
                n_nul = 1'b0;
            end else begin
                n_pos = pos_inc;
                n_pct = r_pct | (b == CH_PERCENT);
                n_pm  = m_pm;
                n_rm  = m_rm;
                n_pf  = m_pf;
                n_rf  = m_rf;
                n_nul = m_nul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_pct <= 1'b0;
            r_pm  <= '0;
            r_rm  <= '0;
            r_pf  <= 1'b0;
            r_rf  <= 1'b0;
            r_nul <= 1'b0;
        end else if (i_fire) begin
            r_pos <= n_pos;
            r_pct <= n_pct;
            r_pm  <= n_pm;
            r_rm  <= n_rm;
            r_pf  <= n_pf;
            r_rf  <= n_rf;
            r_nul <= n_nul;
        end
    end

`include "uart_reply_framer_init_sequencer_top_macros.svh"

    `URF_ASSERT_SAME(a_pos_below_limit, 1'b1, r_pos < POS_LIMIT)
    `URF_ASSERT_SAME(a_reboot_prog_range, 1'b1, r_rm <= REBOOT_LAST)

endmodule

`default_nettype wire

[rtl/urf_sequencer.sv]
// start-up command chain stepped by accepted replies and start events
// depends on urf_pkg
`default_nettype none

module urf_sequencer (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_fire,
    input  wire  [1:0]                i_op,
    input  wire urf_pkg::t_frame_evt  i_evt,
    output urf_pkg::t_seq_res         o_res
);
    import urf_pkg::*;

    logic [2:0] r_await, n_await;
    logic       r_dmode, n_dmode;
    logic [2:0] issued;

    always_comb begin
        n_await = r_await;
        n_dmode = r_dmode;
        issued  = CMD_IDLE;
        case (i_op)
            OP_BYTE: begin
                if (i_evt.reply_accepted) begin
                    case (r_await)
                        CMD_ENTER: begin
                            n_await = CMD_DUMP;
                            issued  = CMD_DUMP;
                        end
                        CMD_DUMP: begin
                            n_await = CMD_GET_NAME;
                            issued  = CMD_GET_NAME;
                        end
                        CMD_GET_NAME: begin
                            n_await = CMD_VERSION;
                            issued  = CMD_VERSION;
                        end
                        CMD_VERSION: begin
                            n_await = CMD_SET_SVC;
                            issued  = CMD_SET_SVC;
                        end
                        CMD_SET_SVC: begin
                            n_await = CMD_RESTART;
                            issued  = CMD_RESTART;
                        end
                        CMD_RESTART: begin
                            n_await = CMD_IDLE;
                            n_dmode = 1'b1;
                        end
                        default: begin
                            n_await = CMD_IDLE;
                        end
                    endcase
                end
            end
            OP_START_COLD: begin
                n_await = CMD_ENTER;
                issued  = CMD_ENTER;
            end
            OP_START_WARM: begin
                n_await = CMD_DUMP;
                issued  = CMD_DUMP;
            end
            default: begin
                n_await = r_await;
            end
        endcase
    end

    assign o_res.command_issued = issued;
    assign o_res.sequence_step  = n_await;
    assign o_res.data_mode      = n_dmode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= CMD_IDLE;
            r_dmode <= 1'b0;
        end else if (i_fire) begin
            r_await <= n_await;
            r_dmode <= n_dmode;
        end
    end

`include "uart_reply_framer_init_sequencer_top_macros.svh"

    `URF_ASSERT_NEXT(a_dmode_sticky, r_dmode, r_dmode)
    `URF_ASSERT_SAME(a_await_no_spare, 1'b1, r_await != 3'd7)

endmodule

`default_nettype wire
